@@ rtl/char_lcd_nibble_write_sequencer_unit_assert.svh @@
// Assertion macros shared by the LCD write sequencer modules.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Clocked property check with reset disable.
`define CLCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be true at a clock edge.
`define CLCD_ASSERT_NEVER(label, clk, rst, expr, msg) \
   `CLCD_ASSERT(label, clk, rst, !(expr), msg)
`else
`define CLCD_ASSERT(label, clk, rst, prop, msg)
`define CLCD_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

@@ rtl/clcd_pkg.sv @@
// Types, codes and the init step table of the LCD write sequencer.
package clcd_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_UP_WAIT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUSY_WAIT        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_EXTRA_WAIT  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR_EXTRA_WAIT = 2'd3;

   localparam logic [15:0] POWER_UP_WAIT_RST    = 16'd15000;
   localparam logic [13:0] BUSY_WAIT_RST        = 14'd4000;
   localparam logic [13:0] CHAR_EXTRA_WAIT_RST  = 14'd1000;
   localparam logic [15:0] CLEAR_EXTRA_WAIT_RST = 16'd50000;

   // Request modes
   localparam logic [2:0] MODE_INIT    = 3'd0;
   localparam logic [2:0] MODE_COMMAND = 3'd1;
   localparam logic [2:0] MODE_DATA    = 3'd2;
   localparam logic [2:0] MODE_PLACE   = 3'd3;
   localparam logic [2:0] MODE_TEXT    = 3'd4;
   localparam logic [2:0] MODE_CGRAM   = 3'd5;

   // Rows and command bytes
   localparam logic [2:0] ROW_1 = 3'd1;
   localparam logic [2:0] ROW_2 = 3'd2;
   localparam logic [2:0] ROW_3 = 3'd3;
   localparam logic [2:0] ROW_4 = 3'd4;
   localparam logic [7:0] ROW_1_BASE = 8'h80;
   localparam logic [7:0] ROW_2_BASE = 8'hC0;
   localparam logic [7:0] ROW_3_BASE = 8'h94;
   localparam logic [7:0] ROW_4_BASE = 8'hD4;
   localparam logic [7:0] CMD_CLEAR  = 8'h01;
   localparam logic [1:0] CGRAM_CMD_TOP = 2'b01;
   localparam int         CGRAM_SLOTS   = 8;
   localparam logic [4:0] CHARS_LEFT_MAX = 5'd31;

   // Step counter
   localparam int         STEP_W         = 5;
   localparam logic [4:0] INIT_LAST_STEP = 5'd21;
   localparam logic [4:0] BYTE_LAST_STEP = 5'd3;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      JOB_INIT,
      JOB_CMD,
      JOB_DATA
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   data;
   } job_type;

   typedef enum logic [2:0] {
      HOLD_ZERO,
      HOLD_POWER,
      HOLD_BUSY,
      HOLD_BUSY2,
      HOLD_CHAR
   } hold_sel_type;

   typedef struct packed {
      logic [3:0]   nibble;
      logic         enable;
      logic         light;
      hold_sel_type hold_sel;
   } step_type;

   typedef struct packed {
      logic [15:0] power_up_wait;
      logic [13:0] busy_wait;
      logic [13:0] char_extra_wait;
      logic [15:0] clear_extra_wait;
   } cfg_type;

   // Init sequence: power-up wait, 3,3,3,2 nibbles, backlight step, 0x28, 0x0c, 0x06
   function automatic step_type init_step(input logic [STEP_W-1:0] idx);
      step_type s;
      s = '{nibble: 4'h0, enable: 1'b0, light: 1'b0, hold_sel: HOLD_ZERO};
      case (idx)
         5'd0:  s = '{4'h0, 1'b0, 1'b0, HOLD_POWER};
         5'd1:  s = '{4'h3, 1'b1, 1'b0, HOLD_BUSY};
         5'd2:  s = '{4'h3, 1'b0, 1'b0, HOLD_BUSY};
         5'd3:  s = '{4'h3, 1'b1, 1'b0, HOLD_BUSY};
         5'd4:  s = '{4'h3, 1'b0, 1'b0, HOLD_BUSY};
         5'd5:  s = '{4'h3, 1'b1, 1'b0, HOLD_BUSY};
         5'd6:  s = '{4'h3, 1'b0, 1'b0, HOLD_BUSY};
         5'd7:  s = '{4'h2, 1'b1, 1'b0, HOLD_BUSY};
         5'd8:  s = '{4'h2, 1'b0, 1'b0, HOLD_BUSY};
         5'd9:  s = '{4'h2, 1'b0, 1'b1, HOLD_ZERO};
         5'd10: s = '{4'h2, 1'b1, 1'b0, HOLD_BUSY};
         5'd11: s = '{4'h2, 1'b0, 1'b0, HOLD_BUSY};
         5'd12: s = '{4'h8, 1'b1, 1'b0, HOLD_BUSY};
         5'd13: s = '{4'h8, 1'b0, 1'b0, HOLD_BUSY2};
         5'd14: s = '{4'h0, 1'b1, 1'b0, HOLD_BUSY};
         5'd15: s = '{4'h0, 1'b0, 1'b0, HOLD_BUSY};
         5'd16: s = '{4'hC, 1'b1, 1'b0, HOLD_BUSY};
         5'd17: s = '{4'hC, 1'b0, 1'b0, HOLD_BUSY2};
         5'd18: s = '{4'h0, 1'b1, 1'b0, HOLD_BUSY};
         5'd19: s = '{4'h0, 1'b0, 1'b0, HOLD_BUSY};
         5'd20: s = '{4'h6, 1'b1, 1'b0, HOLD_BUSY};
         5'd21: s = '{4'h6, 1'b0, 1'b0, HOLD_BUSY2};
         default: s = '{4'h0, 1'b0, 1'b0, HOLD_ZERO};
      endcase
      return s;
   endfunction

endpackage

@@ rtl/clcd_if.sv @@
// Request and pin-step channel interfaces of the LCD write sequencer.
interface clcd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] value;
   logic [2:0] row;
   logic [4:0] column;

   modport source (output valid, mode, value, row, column, input ready);
   modport sink (input valid, mode, value, row, column, output ready);
endinterface

interface clcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  bus_nibble;
   logic        reg_select;
   logic        enable;
   logic        backlight_on;
   logic [16:0] hold_ticks;
   logic        last_step;

   modport source (output valid, bus_nibble, reg_select, enable, backlight_on, hold_ticks,
                   last_step, input ready);
   modport sink (input valid, bus_nibble, reg_select, enable, backlight_on, hold_ticks,
                 last_step, output ready);
endinterface

@@ rtl/clcd_front.sv @@
// Request front end: classifies requests into byte jobs and tracks the line count.
`include "char_lcd_nibble_write_sequencer_unit_assert.svh"
module clcd_front #(
   parameter int LINE_WIDTH = 20
) (
   input  logic             clock,
   input  logic             reset,
   clcd_req_if.sink         req,
   output logic             push_valid,
   output clcd_pkg::job_type push_job,
   input  logic             push_ready
);
   import clcd_pkg::*;

   localparam int SumW = ($clog2(LINE_WIDTH + 2) > 5) ? $clog2(LINE_WIDTH + 2) : 5;
   localparam logic [SumW-1:0] Limit = SumW'(LINE_WIDTH + 1);

   logic [4:0]      chars_left_ff, chars_left_in;
   logic            accept;
   logic [SumW-1:0] col_ext;
   logic [SumW-1:0] diff;
   logic [4:0]      place_count;
   logic [7:0]      row_base;
   logic            row_ok;

   assign accept    = req.valid && req.ready;
   assign req.ready = push_ready;

   // Count of characters left after a placement, clamped to 0..31
   always_comb begin
      col_ext = SumW'(req.column);
      diff    = Limit - col_ext;
      if (col_ext > Limit) begin
         place_count = '0;
      end else if (diff > SumW'(CHARS_LEFT_MAX)) begin
         place_count = CHARS_LEFT_MAX;
      end else begin
         place_count = diff[4:0];
      end
   end

   // Row to DDRAM base address
   always_comb begin
      row_ok   = 1'b1;
      row_base = ROW_1_BASE;
      case (req.row)
         ROW_1:   row_base = ROW_1_BASE;
         ROW_2:   row_base = ROW_2_BASE;
         ROW_3:   row_base = ROW_3_BASE;
         ROW_4:   row_base = ROW_4_BASE;
         default: row_ok = 1'b0;
      endcase
   end

   // Classify the item and update the count
   always_comb begin
      push_valid    = 1'b0;
      push_job      = '{kind: JOB_CMD, data: req.value};
      chars_left_in = chars_left_ff;
      case (req.mode)
         MODE_INIT: begin
            push_valid    = req.valid;
            push_job.kind = JOB_INIT;
         end
         MODE_COMMAND: begin
            push_valid = req.valid;
         end
         MODE_DATA: begin
            push_valid    = req.valid;
            push_job.kind = JOB_DATA;
         end
         MODE_PLACE: begin
            push_valid    = req.valid && row_ok;
            push_job.data = row_base + {3'b000, req.column} + 8'hFF;
            if (accept) begin
               chars_left_in = place_count;
            end
         end
         MODE_TEXT: begin
            push_valid    = req.valid && (chars_left_ff != '0);
            push_job.kind = JOB_DATA;
            if (accept && (chars_left_ff != '0)) begin
               chars_left_in = chars_left_ff - 5'd1;
            end
         end
         MODE_CGRAM: begin
            push_valid    = req.valid && (req.value < 8'(CGRAM_SLOTS));
            push_job.data = {CGRAM_CMD_TOP, req.value[2:0], 3'b000};
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

   // Hold the count
   always_ff @(posedge clock) begin
      if (reset) begin
         chars_left_ff <= '0;
      end else begin
         chars_left_ff <= chars_left_in;
      end
   end

   `CLCD_ASSERT(a_text_empty_holds, clock, reset,
      (accept && req.mode == MODE_TEXT && chars_left_ff == '0) |=> (chars_left_ff == '0),
      "clipped text changed an empty count")

endmodule

@@ rtl/clcd_fifo.sv @@
// Short job queue between the front end and the step sequencer.
`include "char_lcd_nibble_write_sequencer_unit_assert.svh"
module clcd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  clcd_pkg::job_type push_job,
   output logic              push_ready,
   output logic              pop_valid,
   output clcd_pkg::job_type pop_job,
   input  logic              pop_ready
);
   import clcd_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   job_type         slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != CntW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `CLCD_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CntW'(QUEUE_DEPTH),
      "job queue count beyond depth")

endmodule

@@ rtl/clcd_back.sv @@
// Step sequencer: expands a job into output register steps, one per cycle unless stalled.
`include "char_lcd_nibble_write_sequencer_unit_assert.svh"
module clcd_back (
   input  logic              clock,
   input  logic              reset,
   input  clcd_pkg::cfg_type cfg,
   input  logic              pop_valid,
   input  clcd_pkg::job_type pop_job,
   output logic              pop_ready,
   clcd_rsp_if.source        rsp
);
   import clcd_pkg::*;

   logic              busy_ff, busy_in;
   job_type           job_ff, job_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              light_ff, light_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_nibble_ff, rsp_nibble_in;
   logic        rsp_rs_ff, rsp_rs_in;
   logic        rsp_enable_ff, rsp_enable_in;
   logic        rsp_light_ff, rsp_light_in;
   logic [16:0] rsp_hold_ff, rsp_hold_in;
   logic        rsp_last_ff, rsp_last_in;

   step_type          cur;
   logic              is_last;
   logic              advance;
   logic [16:0]       hold;
   logic              is_clear;

   assign pop_ready = !busy_ff;
   assign advance   = busy_ff && (!rsp_valid_ff || rsp.ready);
   assign is_last   = (job_ff.kind == JOB_INIT) ? (step_ff == INIT_LAST_STEP)
                                                : (step_ff == BYTE_LAST_STEP);
   assign is_clear  = (job_ff.kind == JOB_CMD) && (job_ff.data == CMD_CLEAR);

   // Decode the current step
   always_comb begin
      cur = init_step(step_ff);
      case (job_ff.kind)
         JOB_INIT: begin
            cur = init_step(step_ff);
         end
         JOB_CMD: begin
            cur.nibble   = step_ff[1] ? job_ff.data[3:0] : job_ff.data[7:4];
            cur.enable   = !step_ff[0];
            cur.light    = 1'b0;
            cur.hold_sel = (step_ff[1:0] == 2'd3) ? HOLD_BUSY2 : HOLD_BUSY;
         end
         JOB_DATA: begin
            cur.nibble   = step_ff[1] ? job_ff.data[3:0] : job_ff.data[7:4];
            cur.enable   = !step_ff[0];
            cur.light    = 1'b0;
            cur.hold_sel = (step_ff[1:0] == 2'd3) ? HOLD_CHAR : HOLD_ZERO;
         end
         default: begin
            cur = init_step(step_ff);
         end
      endcase
   end

   // Select the hold time
   always_comb begin
      case (cur.hold_sel)
         HOLD_ZERO:  hold = '0;
         HOLD_POWER: hold = 17'(cfg.power_up_wait);
         HOLD_BUSY:  hold = 17'(cfg.busy_wait);
         HOLD_BUSY2: hold = 17'({cfg.busy_wait, 1'b0})
                            + (is_clear ? 17'(cfg.clear_extra_wait) : 17'd0);
         HOLD_CHAR:  hold = 17'(cfg.busy_wait) + 17'(cfg.char_extra_wait);
         default:    hold = '0;
      endcase
   end

   // Load a job, advance steps, drain the output register
   always_comb begin
      busy_in       = busy_ff;
      job_in        = job_ff;
      step_in       = step_ff;
      light_in      = light_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_nibble_in = rsp_nibble_ff;
      rsp_rs_in     = rsp_rs_ff;
      rsp_enable_in = rsp_enable_ff;
      rsp_light_in  = rsp_light_ff;
      rsp_hold_in   = rsp_hold_ff;
      rsp_last_in   = rsp_last_ff;
      if (!busy_ff && pop_valid) begin
         busy_in = 1'b1;
         job_in  = pop_job;
         step_in = '0;
      end
      if (advance) begin
         rsp_valid_in  = 1'b1;
         rsp_nibble_in = cur.nibble;
         rsp_rs_in     = (job_ff.kind == JOB_DATA);
         rsp_enable_in = cur.enable;
         rsp_light_in  = light_ff | cur.light;
         rsp_hold_in   = hold;
         rsp_last_in   = is_last;
         if (cur.light) begin
            light_in = 1'b1;
         end
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         light_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         light_ff     <= light_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold job and step payload
   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      rsp_nibble_ff <= rsp_nibble_in;
      rsp_rs_ff     <= rsp_rs_in;
      rsp_enable_ff <= rsp_enable_in;
      rsp_light_ff  <= rsp_light_in;
      rsp_hold_ff   <= rsp_hold_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.bus_nibble   = rsp_nibble_ff;
   assign rsp.reg_select   = rsp_rs_ff;
   assign rsp.enable       = rsp_enable_ff;
   assign rsp.backlight_on = rsp_light_ff;
   assign rsp.hold_ticks   = rsp_hold_ff;
   assign rsp.last_step    = rsp_last_ff;

   `CLCD_ASSERT(a_byte_step_range, clock, reset,
      (busy_ff && job_ff.kind != JOB_INIT) |-> (step_ff <= BYTE_LAST_STEP),
      "byte job step counter out of range")
   `CLCD_ASSERT(a_last_frees, clock, reset, (advance && is_last) |=> !busy_ff,
      "sequencer still busy after last step")

endmodule

@@ rtl/char_lcd_nibble_write_sequencer_unit.sv @@
// Top level of the 4-bit character LCD write sequencer.
// Requests enter on req_chan (valid/ready): mode, value, row, column. Each
// request becomes a run of pin steps on rsp_chan (valid/ready), each with the
// nibble, RS, E, backlight level, hold time in ticks and a last-step flag.
// Commands, data, placements and CGRAM selects give 4 steps; init gives 22;
// dropped requests (bad row, empty line count, bad slot, unused mode) give none.
// The front end takes a request and queues a byte job (2 deep).
// The step sequencer loads a job, then emits one step per cycle into the output
// register while rsp_chan is not stalled; a request's first step passes through
// the queue, the job register and the output register before it is visible.
// A stall on rsp_chan holds the output register; the queue keeps taking
// requests until it is full, then req_chan.ready drops.
// The csr port writes the wait registers by index; write them only while
// the block is idle. Synchronous reset restores the default waits,
// clears the line count, switches the backlight flag off and empties the queue.
module char_lcd_nibble_write_sequencer_unit #(
   parameter int LINE_WIDTH = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   clcd_req_if.sink                         req_chan,
   clcd_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [clcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [clcd_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import clcd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push_valid;
   job_type push_job;
   logic    push_ready;
   logic    pop_valid;
   job_type pop_job;
   logic    pop_ready;

   // Write the wait registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_POWER_UP_WAIT:    cfg_in.power_up_wait    = csr_write_data;
            CSR_BUSY_WAIT:        cfg_in.busy_wait        = csr_write_data[13:0];
            CSR_CHAR_EXTRA_WAIT:  cfg_in.char_extra_wait  = csr_write_data[13:0];
            CSR_CLEAR_EXTRA_WAIT: cfg_in.clear_extra_wait = csr_write_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{power_up_wait:    POWER_UP_WAIT_RST,
                     busy_wait:        BUSY_WAIT_RST,
                     char_extra_wait:  CHAR_EXTRA_WAIT_RST,
                     clear_extra_wait: CLEAR_EXTRA_WAIT_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clcd_front #(
      .LINE_WIDTH (LINE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   clcd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   clcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_ready (pop_ready),
      .rsp       (rsp_chan)
   );

endmodule

@@ tb/char_lcd_nibble_write_sequencer_unit_tb.sv @@
// Self-checking testbench of the 4-bit character LCD write sequencer.
module char_lcd_nibble_write_sequencer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import clcd_pkg::*;

   localparam int LINE_WIDTH = 20;
   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;
   localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] CMD_CGRAM_ADDR   = 8'h40;
   localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
   localparam logic [3:0] FOUR_BIT_NIBBLE  = 4'h2;
   localparam int PHASES           = 5;
   localparam int WRITES_PER_PHASE = 61;
   localparam int SETTLE_CYCLES    = 12;
   localparam int REPORT_CAP       = 100;
   localparam int NUM_DIRECTED     = 24;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] value;
      logic [2:0] row;
      logic [4:0] column;
   } lcd_request_type;

   typedef struct packed {
      logic [3:0]  bus_nibble;
      logic        reg_select;
      logic        enable;
      logic        backlight_on;
      logic [16:0] hold_ticks;
      logic        last_step;
   } pin_step_type;

   // known: step count and final hold are read straight off the spec
   typedef struct packed {
      lcd_request_type req;
      logic            known;
      logic [4:0]      steps;
      logic [16:0]     tail_hold;
   } directed_row_type;

   // Directed items, all under the reset wait values
   localparam directed_row_type DIRECTED [NUM_DIRECTED] = '{
      '{'{MODE_TEXT,    8'h41, 3'd0,  5'd0},  1'b1, 5'd0,  17'd0},
      '{'{MODE_COMMAND, CMD_CLEAR, 3'd0, 5'd0}, 1'b1, 5'd4, 17'd58000},
      '{'{MODE_INIT,    8'h00, 3'd0,  5'd0},  1'b1, 5'd22, 17'd8000},
      '{'{MODE_COMMAND, 8'h00, 3'd0,  5'd0},  1'b1, 5'd4,  17'd8000},
      '{'{MODE_COMMAND, 8'hFF, 3'd7,  5'd31}, 1'b0, 5'd0,  17'd0},
      '{'{MODE_DATA,    8'h00, 3'd0,  5'd0},  1'b1, 5'd4,  17'd5000},
      '{'{MODE_DATA,    8'hFF, 3'd7,  5'd31}, 1'b0, 5'd0,  17'd0},
      '{'{MODE_PLACE,   8'h00, 3'd0,  5'd5},  1'b1, 5'd0,  17'd0},
      '{'{MODE_TEXT,    8'h5A, 3'd0,  5'd0},  1'b0, 5'd0,  17'd0},
      '{'{MODE_PLACE,   8'h00, ROW_1, 5'd1},  1'b0, 5'd0,  17'd0},
      '{'{MODE_PLACE,   8'h00, ROW_2, 5'd31}, 1'b0, 5'd0,  17'd0},
      '{'{MODE_TEXT,    8'h20, 3'd0,  5'd0},  1'b1, 5'd0,  17'd0},
      '{'{MODE_PLACE,   8'h00, ROW_3, 5'd0},  1'b0, 5'd0,  17'd0},
      '{'{MODE_PLACE,   8'h00, ROW_4, 5'd20}, 1'b0, 5'd0,  17'd0},
      '{'{MODE_TEXT,    8'h7E, 3'd0,  5'd0},  1'b0, 5'd0,  17'd0},
      '{'{MODE_TEXT,    8'h7F, 3'd0,  5'd0},  1'b1, 5'd0,  17'd0},
      '{'{MODE_PLACE,   8'h00, 3'd5,  5'd1},  1'b1, 5'd0,  17'd0},
      '{'{MODE_PLACE,   8'h00, 3'd7,  5'd31}, 1'b1, 5'd0,  17'd0},
      '{'{MODE_CGRAM,   8'h00, 3'd0,  5'd0},  1'b0, 5'd0,  17'd0},
      '{'{MODE_CGRAM,   8'h07, 3'd0,  5'd0},  1'b0, 5'd0,  17'd0},
      '{'{MODE_CGRAM,   8'h08, 3'd0,  5'd0},  1'b1, 5'd0,  17'd0},
      '{'{MODE_CGRAM,   8'hFF, 3'd0,  5'd0},  1'b1, 5'd0,  17'd0},
      '{'{MODE_SPARE_6, 8'hFF, 3'd7,  5'd31}, 1'b1, 5'd0,  17'd0},
      '{'{MODE_SPARE_7, 8'h00, 3'd0,  5'd0},  1'b1, 5'd0,  17'd0}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   clcd_req_if req_bus ();
   clcd_rsp_if rsp_bus ();

   // Mirror of the block's wait registers, line count and backlight
   cfg_type      wait_cfg;
   logic [4:0]   line_room;
   logic         light_flag;
   pin_step_type planned[$];
   pin_step_type awaited_steps[$];
   int unsigned  step_faults = 0;

   char_lcd_nibble_write_sequencer_unit #(.LINE_WIDTH(LINE_WIDTH)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic void add_step(input logic [3:0] nibble, input logic rs, input logic en,
                                    input logic [16:0] hold);
      pin_step_type s;
      s.bus_nibble   = nibble;
      s.reg_select   = rs;
      s.enable       = en;
      s.backlight_on = light_flag;
      s.hold_ticks   = hold;
      s.last_step    = 1'b0;
      planned.push_back(s);
   endfunction

   // Command byte: two nibbles, each strobed; the tail holds twice the busy wait, plus the clear extra wait for a clear
   function automatic void add_command(input logic [7:0] b);
      logic [16:0] busy, tail;
      busy = 17'(wait_cfg.busy_wait);
      tail = busy + busy;
      if (b == CMD_CLEAR) tail = tail + 17'(wait_cfg.clear_extra_wait);
      add_step(b[7:4], 1'b0, 1'b1, busy);
      add_step(b[7:4], 1'b0, 1'b0, busy);
      add_step(b[3:0], 1'b0, 1'b1, busy);
      add_step(b[3:0], 1'b0, 1'b0, tail);
   endfunction

   // Data byte: no hold until the final step
   function automatic void add_data(input logic [7:0] b);
      logic [16:0] tail;
      tail = 17'(wait_cfg.busy_wait) + 17'(wait_cfg.char_extra_wait);
      add_step(b[7:4], 1'b1, 1'b1, 17'd0);
      add_step(b[7:4], 1'b1, 1'b0, 17'd0);
      add_step(b[3:0], 1'b1, 1'b1, 17'd0);
      add_step(b[3:0], 1'b1, 1'b0, tail);
   endfunction

   // Work out the pin steps of one item and advance the mirrored state
   function automatic int plan_request(input lcd_request_type r);
      int           room;
      logic [7:0]   row_base;
      pin_step_type tail_step;
      planned.delete();
      case (r.mode)
         MODE_INIT: begin
            add_step(4'h0, 1'b0, 1'b0, 17'(wait_cfg.power_up_wait));
            for (int i = 0; i < 4; i++) begin
               add_step((i < 3) ? WAKE_NIBBLE : FOUR_BIT_NIBBLE, 1'b0, 1'b1,
                        17'(wait_cfg.busy_wait));
               add_step((i < 3) ? WAKE_NIBBLE : FOUR_BIT_NIBBLE, 1'b0, 1'b0,
                        17'(wait_cfg.busy_wait));
            end
            light_flag = 1'b1;
            add_step(FOUR_BIT_NIBBLE, 1'b0, 1'b0, 17'd0);
            add_command(CMD_FUNCTION_SET);
            add_command(CMD_DISPLAY_ON);
            add_command(CMD_ENTRY_MODE);
         end
         MODE_COMMAND: add_command(r.value);
         MODE_DATA:    add_data(r.value);
         MODE_PLACE: begin
            // the line count is set even when the row is out of range
            room = LINE_WIDTH + 1 - int'(r.column);
            if (room < 0) room = 0;
            if (room > 31) room = 31;
            line_room = 5'(room);
            case (r.row)
               ROW_1:   row_base = ROW_1_BASE;
               ROW_2:   row_base = ROW_2_BASE;
               ROW_3:   row_base = ROW_3_BASE;
               ROW_4:   row_base = ROW_4_BASE;
               default: row_base = 8'h00;
            endcase
            if (row_base != 8'h00) add_command(row_base + {3'b000, r.column} - 8'd1);
         end
         MODE_TEXT: begin
            if (line_room != 5'd0) begin
               add_data(r.value);
               line_room = line_room - 5'd1;
            end
         end
         MODE_CGRAM: begin
            if (r.value < CGRAM_SLOTS) add_command(CMD_CGRAM_ADDR + {2'b00, r.value[2:0], 3'b000});
         end
         default: ;
      endcase
      if (planned.size() > 0) begin
         tail_step = planned.pop_back();
         tail_step.last_step = 1'b1;
         planned.push_back(tail_step);
      end
      return planned.size();
   endfunction

   // Mostly no idle, sometimes a few cycles, rarely a long pause
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 15);
      if (roll < 8) return 0;
      if (roll < 14) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Most placements are followed by runs of text chars; the rest is mixed traffic
   function automatic lcd_request_type random_request(inout int text_run);
      lcd_request_type r;
      int              pick;
      r.value  = 8'($urandom);
      r.row    = 3'($urandom);
      r.column = 5'($urandom);
      r.mode   = MODE_TEXT;
      pick     = $urandom_range(0, 99);
      if (text_run > 0) begin
         text_run--;
      end else if (pick < 15) begin
         r.mode = MODE_PLACE;
         r.row  = 3'($urandom_range(1, 4));
         if ($urandom_range(0, 4) != 0) r.column = 5'($urandom_range(1, LINE_WIDTH));
         text_run = $urandom_range(0, 24);
      end else if (pick < 20) begin
         r.mode = MODE_PLACE;
      end else if (pick < 40) begin
         r.mode = MODE_COMMAND;
         if ($urandom_range(0, 7) == 0) r.value = CMD_CLEAR;
      end else if (pick < 60) begin
         r.mode = MODE_DATA;
      end else if (pick < 68) begin
         r.mode = MODE_CGRAM;
         if ($urandom_range(0, 3) != 0) r.value = 8'($urandom_range(0, CGRAM_SLOTS - 1));
      end else if (pick < 70) begin
         r.mode = MODE_INIT;
      end else if (pick < 75) begin
         r.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE_6 : MODE_SPARE_7;
      end
      return r;
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         step_faults++;
         if (step_faults <= REPORT_CAP)
            $error("%s: expected %0d, got %0d", field, want, got);
      end
   endtask

   // Offer one item after an idle gap; plan its steps once it is taken
   task automatic send_request(input lcd_request_type r, input int gap, output int produced);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.mode   <= r.mode;
      req_bus.value  <= r.value;
      req_bus.row    <= r.row;
      req_bus.column <= r.column;
      do @(posedge clock); while (!req_bus.ready);
      produced = plan_request(r);
      foreach (planned[i]) awaited_steps.push_back(planned[i]);
      @(negedge clock);
   endtask

   // Hold the sender until every awaited step has come out
   task automatic drain_steps();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (awaited_steps.size() != 0);
   endtask

   task automatic write_wait_reg(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      case (idx)
         CSR_POWER_UP_WAIT:    wait_cfg.power_up_wait    = data;
         CSR_BUSY_WAIT:        wait_cfg.busy_wait        = data[13:0];
         CSR_CHAR_EXTRA_WAIT:  wait_cfg.char_extra_wait  = data[13:0];
         CSR_CLEAR_EXTRA_WAIT: wait_cfg.clear_extra_wait = data;
         default: ;
      endcase
   endtask

   // Stall the step output in random windows, with long open stretches now and then
   initial begin : step_sink
      int open_len, stall_len;
      rsp_bus.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
         rsp_bus.ready <= 1'b1;
         repeat (open_len) @(negedge clock);
         stall_len = pick_gap();
         if (stall_len > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall_len) @(negedge clock);
         end
      end
   end

   // Compare each accepted step with the oldest awaited one
   always @(posedge clock) begin : step_check
      pin_step_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_steps.size() == 0) begin
            step_faults++;
            if (step_faults <= REPORT_CAP)
               $error("unexpected pin step: nibble %0h, hold_ticks %0d",
                      rsp_bus.bus_nibble, rsp_bus.hold_ticks);
         end else begin
            want = awaited_steps.pop_front();
            compare_field("bus_nibble", want.bus_nibble, rsp_bus.bus_nibble);
            compare_field("reg_select", want.reg_select, rsp_bus.reg_select);
            compare_field("enable", want.enable, rsp_bus.enable);
            compare_field("backlight_on", want.backlight_on, rsp_bus.backlight_on);
            compare_field("hold_ticks", want.hold_ticks, rsp_bus.hold_ticks);
            compare_field("last_step", want.last_step, rsp_bus.last_step);
         end
      end
   end

   initial begin : stimulus
      lcd_request_type r;
      int              produced, gap, text_run, calm_left, writes_done;
      logic [15:0]     w_power, w_busy, w_char, w_clear;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.mode     <= '0;
      req_bus.value    <= '0;
      req_bus.row      <= '0;
      req_bus.column   <= '0;
      wait_cfg.power_up_wait    = POWER_UP_WAIT_RST;
      wait_cfg.busy_wait        = BUSY_WAIT_RST;
      wait_cfg.char_extra_wait  = CHAR_EXTRA_WAIT_RST;
      wait_cfg.clear_extra_wait = CLEAR_EXTRA_WAIT_RST;
      line_room  = 5'd0;
      light_flag = 1'b0;
      text_run   = 0;
      calm_left  = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table; cross-check the known rows with hand-read results
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_request(DIRECTED[i].req, pick_gap(), produced);
         if (DIRECTED[i].known && (produced != int'(DIRECTED[i].steps) ||
             (produced > 0 && planned[produced-1].hold_ticks != DIRECTED[i].tail_hold))) begin
            step_faults++;
            $error("directed item %0d: expected %0d steps ending on hold %0d, planned %0d",
                   i, DIRECTED[i].steps, DIRECTED[i].tail_hold, produced);
         end
      end

      // Random traffic, one wait setting per phase, written while idle
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_steps();
         repeat (SETTLE_CYCLES) @(negedge clock);
         case (phase)
            0: begin
               w_power = 16'h0000; w_busy = 16'h0000; w_char = 16'h0000; w_clear = 16'h0000;
            end
            1: begin
               w_power = 16'hFFFF; w_busy = 16'hFFFF; w_char = 16'hFFFF; w_clear = 16'hFFFF;
            end
            2: begin
               w_power = 16'($urandom_range(0, 65535));
               w_busy  = 16'($urandom_range(0, 16383));
               w_char  = 16'($urandom_range(0, 16383));
               w_clear = 16'($urandom_range(0, 65535));
            end
            3: begin
               w_power = 16'($urandom_range(0, 15));
               w_busy  = 16'($urandom_range(0, 15));
               w_char  = 16'($urandom_range(0, 15));
               w_clear = 16'($urandom_range(0, 15));
            end
            default: begin
               w_power = 16'($urandom);
               w_busy  = 16'($urandom);
               w_char  = 16'($urandom);
               w_clear = 16'($urandom);
            end
         endcase
         write_wait_reg(CSR_POWER_UP_WAIT, w_power);
         write_wait_reg(CSR_BUSY_WAIT, w_busy);
         write_wait_reg(CSR_CHAR_EXTRA_WAIT, w_char);
         write_wait_reg(CSR_CLEAR_EXTRA_WAIT, w_clear);
         csr_write_enable <= 1'b0;

         writes_done = 0;
         while (writes_done < WRITES_PER_PHASE) begin
            // now and then let the output run dry before the next item
            if ($urandom_range(0, 59) == 0) drain_steps();
            r = random_request(text_run);
            if (calm_left > 0) begin
               gap = 0;
               calm_left--;
            end else begin
               gap = pick_gap();
               if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(10, 40);
            end
            send_request(r, gap, produced);
            writes_done++;
         end
      end

      drain_steps();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (step_faults == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #(50_000_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/clcd_pkg.sv
rtl/clcd_if.sv
rtl/clcd_front.sv
rtl/clcd_fifo.sv
rtl/clcd_back.sv
rtl/char_lcd_nibble_write_sequencer_unit.sv
tb/char_lcd_nibble_write_sequencer_unit_tb.sv
